// ----- rtl/core/lr_pkg.sv -----
// Package for the clipped line rasterizer: shared widths, codes, command and
// status structs between controller and datapath, and the endpoint rounding.
// No dependencies.
package lr_pkg;

  localparam int COORD_BITS   = 16;                // signed Q12.4 endpoint coordinates
  localparam int FRAC_BITS    = 4;
  localparam int PIX_BITS     = 13;                // signed integer pixel coordinate
  localparam int ADDR_BITS    = 24;
  localparam int SIDE_BITS    = 13;
  localparam int MAX_SIDE     = 4096;
  localparam int DELTA_BITS   = COORD_BITS + 1;    // endpoint difference
  localparam int PROD_BITS    = COORD_BITS + 2;    // operands of the load multiply
  localparam int NUM_BITS     = 2 * PROD_BITS;     // signed interpolation numerator
  localparam int MAG_BITS     = NUM_BITS - 1;
  localparam int DEN_BITS     = COORD_BITS + FRAC_BITS + 1;  // 32 * delta_major
  localparam int QUO_BITS     = PIX_BITS;          // quotient bits the divider produces
  localparam int CNT_BITS     = $clog2(QUO_BITS + 1);
  localparam int T0_BITS      = FRAC_BITS + 1;
  localparam int SMALL_BITS   = T0_BITS + DELTA_BITS + 1;
  localparam int REG_IDX_BITS = 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PIX_BITS-1:0]   pix_t;
  typedef logic [SIDE_BITS-1:0]         side_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch and order the endpoints of a new line
    logic step;       // emit the current pixel and advance
    logic mul;        // form the numerator products and the step increments
    logic degen;      // commit a line whose major extent is zero
    logic sum;        // add the products and split off the sign
    logic div_start;  // start the numerator division
    logic fix;        // apply floor correction and commit the line
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic line_active;
    logic degen;
    logic out_valid;
    logic div_done;
  } dp_stat_t;

  // round(a) = floor(a + 1/2) for a Q12.4 value, giving an integer pixel.
  function automatic pix_t round_fix(coord_t a);
    logic signed [COORD_BITS:0] t;
    t = (COORD_BITS + 1)'(a) + (COORD_BITS + 1)'(1 << (FRAC_BITS - 1));
    return t[COORD_BITS:FRAC_BITS];
  endfunction

endpackage

// ----- rtl/core/lr_div.sv -----
// Restoring divider for the clipped line rasterizer: one quotient bit a cycle.
// Depends on lr_pkg.
module lr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lr_pkg::MAG_BITS-1:0] dividend,
  input  logic [lr_pkg::DEN_BITS-1:0] divisor,
  output logic                        done,
  output logic [lr_pkg::QUO_BITS-1:0] quotient,
  output logic [lr_pkg::DEN_BITS-1:0] remainder
);
  import lr_pkg::*;

  logic                busy_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DEN_BITS-1:0] rem_r;
  logic [QUO_BITS-1:0] lo_r;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // The quotient is known to stay below 2^QUO_BITS, so the upper dividend
  // bits are already smaller than the divisor.
  assign trial = {rem_r, lo_r[QUO_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(QUO_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_BITS'(dividend >> QUO_BITS);
      lo_r  <= dividend[QUO_BITS-1:0];
    end else if (busy_r) begin
      rem_r <= fits ? DEN_BITS'(trial - {1'b0, divisor}) : DEN_BITS'(trial);
      lo_r  <= {lo_r[QUO_BITS-2:0], fits};
    end
  end

  assign done      = busy_r && (cnt_r == CNT_BITS'(1));
  assign quotient  = lo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/lr_dp.sv -----
// Datapath of the clipped line rasterizer: endpoint ordering, load-time
// numerator and division, incremental minor-axis stepping, clipping, output word.
// Depends on lr_pkg and lr_div.
module lr_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lr_pkg::dp_cmd_t                 cmd,
  output lr_pkg::dp_stat_t                stat,
  input  logic                            cfg_we,
  input  logic [lr_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [lr_pkg::SIDE_BITS-1:0]    cfg_wdata,
  input  lr_pkg::coord_t                  start_x,
  input  lr_pkg::coord_t                  start_y,
  input  lr_pkg::coord_t                  end_x,
  input  lr_pkg::coord_t                  end_y,
  input  logic                            out_tready,
  output lr_pkg::pix_t                    out_pixel_x,
  output lr_pkg::pix_t                    out_pixel_y,
  output logic                            out_inside_res,
  output logic [lr_pkg::ADDR_BITS-1:0]    out_pixel_address,
  output logic                            out_last
);
  import lr_pkg::*;

  // Raster size registers.
  side_t width_r, height_r;
  side_t cfg_sat;

  // Line state.
  logic                         maj_x_r;
  coord_t                       a0_r, b0_r;
  logic [DELTA_BITS-1:0]        da_r;
  logic signed [DELTA_BITS-1:0] db_r;
  pix_t                         cur_r, fin_r, minor_r;
  logic [DEN_BITS-1:0]          den_r, rs_r, rem_r;
  logic signed [1:0]            qs_r;
  logic                         line_active_r;

  // Load pipeline.
  logic signed [NUM_BITS-1:0]   prod_r;
  logic signed [SMALL_BITS-1:0] small_r;
  logic                         neg_r;
  logic [MAG_BITS-1:0]          mag_r;

  // Output register.
  logic                         out_valid_r;
  pix_t                         out_px_r, out_py_r;
  logic                         out_inside_r, out_last_r;
  logic [ADDR_BITS-1:0]         out_addr_r;

  // Endpoint ordering.
  logic signed [DELTA_BITS-1:0] dx_c, dy_c, da_c, db_c;
  logic [DELTA_BITS-1:0]        adx_c, ady_c;
  logic                         mx_c, swap_c;
  coord_t                       a0s_c, b0s_c, a1s_c, b1s_c, a0_c, b0_c, a1_c, b1_c;

  // Numerator terms.
  logic signed [COORD_BITS+1:0] t0_full_c;
  logic signed [T0_BITS-1:0]    t0_c;
  logic signed [PROD_BITS-1:0]  b2_c, da_s_c, db_s_c;
  logic signed [NUM_BITS-1:0]   prod_c, num_c;
  logic signed [SMALL_BITS-1:0] small_c;
  logic signed [PROD_BITS-1:0]  rsv_c;
  logic signed [1:0]            qs_c;

  // Divider.
  logic                         div_done;
  logic [QUO_BITS-1:0]          div_q;
  logic [DEN_BITS-1:0]          div_r;
  pix_t                         q_pix;

  // Stepping and clipping.
  pix_t                         px_c, py_c, minor_nxt;
  logic                         inside_c, last_c, wrap_c;
  logic [DEN_BITS:0]            rem_sum_c;
  logic [DEN_BITS-1:0]          rem_nxt;
  logic [ADDR_BITS-1:0]         addr_c;
  logic                         out_valid_nxt;

  // Register writes above the largest raster side saturate.
  assign cfg_sat = (cfg_wdata > SIDE_BITS'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_BITS'(MAX_SIDE);
      height_r <= SIDE_BITS'(MAX_SIDE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_sat;
        REG_HEIGHT: height_r <= cfg_sat;
        default:    ;
      endcase
    end
  end

  // Major axis is x only when |dx| is strictly larger; endpoints are ordered
  // so that the major coordinate ascends.
  always_comb begin
    dx_c   = DELTA_BITS'(end_x) - DELTA_BITS'(start_x);
    dy_c   = DELTA_BITS'(end_y) - DELTA_BITS'(start_y);
    adx_c  = dx_c[DELTA_BITS-1] ? DELTA_BITS'(-dx_c) : DELTA_BITS'(dx_c);
    ady_c  = dy_c[DELTA_BITS-1] ? DELTA_BITS'(-dy_c) : DELTA_BITS'(dy_c);
    mx_c   = adx_c > ady_c;
    a0s_c  = mx_c ? start_x : start_y;
    b0s_c  = mx_c ? start_y : start_x;
    a1s_c  = mx_c ? end_x   : end_y;
    b1s_c  = mx_c ? end_y   : end_x;
    swap_c = a0s_c > a1s_c;
    a0_c   = swap_c ? a1s_c : a0s_c;
    b0_c   = swap_c ? b1s_c : b0s_c;
    a1_c   = swap_c ? a0s_c : a1s_c;
    b1_c   = swap_c ? b0s_c : b1s_c;
    da_c   = DELTA_BITS'(a1_c) - DELTA_BITS'(a0_c);
    db_c   = DELTA_BITS'(b1_c) - DELTA_BITS'(b0_c);
  end

  // Numerator at the first pixel:
  //   N = (2*b0 + 16)*da + 2*t0*db, t0 = 16*round(a0) - a0,
  // and minor = floor(N / (32*da)). Each step adds 32*db to N, which splits
  // into qs whole pixels plus a remainder rs, since |db| <= da.
  always_comb begin
    t0_full_c = (COORD_BITS + 2)'($signed({cur_r, {FRAC_BITS{1'b0}}}))
              - (COORD_BITS + 2)'(a0_r);
    t0_c      = t0_full_c[T0_BITS-1:0];
    b2_c      = (PROD_BITS'(b0_r) <<< 1) + PROD_BITS'(1 << FRAC_BITS);
    da_s_c    = $signed({1'b0, da_r});
    db_s_c    = PROD_BITS'(db_r);
    prod_c    = NUM_BITS'(b2_c) * NUM_BITS'(da_s_c);
    small_c   = (SMALL_BITS'(t0_c) * SMALL_BITS'(db_r)) <<< 1;
    if (db_s_c == da_s_c) begin
      qs_c  = 2'sd1;
      rsv_c = '0;
    end else if (!db_r[DELTA_BITS-1]) begin
      qs_c  = 2'sd0;
      rsv_c = db_s_c;
    end else if (db_s_c == -da_s_c) begin
      qs_c  = -2'sd1;
      rsv_c = '0;
    end else begin
      qs_c  = -2'sd1;
      rsv_c = db_s_c + da_s_c;
    end
    num_c = prod_r + NUM_BITS'(small_r);
  end

  lr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (mag_r),
    .divisor   (den_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign q_pix = pix_t'(div_q);

  // Current pixel, clip test and address.
  always_comb begin
    px_c      = maj_x_r ? cur_r : minor_r;
    py_c      = maj_x_r ? minor_r : cur_r;
    inside_c  = !px_c[PIX_BITS-1] && !py_c[PIX_BITS-1] &&
                (SIDE_BITS'($unsigned(px_c)) < width_r) &&
                (SIDE_BITS'($unsigned(py_c)) < height_r);
    addr_c    = inside_c ? ADDR_BITS'(ADDR_BITS'(px_c[PIX_BITS-2:0]) +
                                      ADDR_BITS'(width_r) * ADDR_BITS'(py_c[PIX_BITS-2:0]))
                         : '0;
    last_c    = cur_r >= fin_r;
    rem_sum_c = {1'b0, rem_r} + {1'b0, rs_r};
    wrap_c    = rem_sum_c >= {1'b0, den_r};
    rem_nxt   = wrap_c ? DEN_BITS'(rem_sum_c - {1'b0, den_r}) : DEN_BITS'(rem_sum_c);
    minor_nxt = minor_r + PIX_BITS'(qs_r) + PIX_BITS'(wrap_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      maj_x_r <= mx_c;
      a0_r    <= a0_c;
      b0_r    <= b0_c;
      da_r    <= DELTA_BITS'(da_c);
      db_r    <= db_c;
      cur_r   <= round_fix(a0_c);
      fin_r   <= round_fix(a1_c);
    end else if (cmd.step && !last_c) begin
      cur_r <= cur_r + PIX_BITS'(1);
    end

    if (cmd.mul) begin
      prod_r  <= prod_c;
      small_r <= small_c;
      den_r   <= DEN_BITS'({da_r, {(FRAC_BITS + 1){1'b0}}});
      rs_r    <= DEN_BITS'({rsv_c[DELTA_BITS-2:0], {(FRAC_BITS + 1){1'b0}}});
      qs_r    <= qs_c;
    end

    if (cmd.sum) begin
      neg_r <= num_c[NUM_BITS-1];
      mag_r <= num_c[NUM_BITS-1] ? MAG_BITS'(-num_c) : MAG_BITS'(num_c);
    end

    if (cmd.degen) begin
      minor_r <= round_fix(b0_r);
      rem_r   <= '0;
    end else if (cmd.fix) begin
      if (!neg_r) begin
        minor_r <= q_pix;
        rem_r   <= div_r;
      end else if (div_r == '0) begin
        minor_r <= -q_pix;
        rem_r   <= '0;
      end else begin
        minor_r <= ~q_pix;
        rem_r   <= den_r - div_r;
      end
    end else if (cmd.step && !last_c) begin
      minor_r <= minor_nxt;
      rem_r   <= rem_nxt;
    end

    if (cmd.step) begin
      out_px_r     <= px_c;
      out_py_r     <= py_c;
      out_inside_r <= inside_c;
      out_addr_r   <= addr_c;
      out_last_r   <= last_c;
    end
  end

  assign out_valid_nxt = cmd.step ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        line_active_r <= 1'b0;
      end else if (cmd.degen || cmd.fix) begin
        line_active_r <= 1'b1;
      end else if (cmd.step && last_c) begin
        line_active_r <= 1'b0;
      end
    end
  end

  assign stat.line_active = line_active_r;
  assign stat.degen       = (da_r == '0);
  assign stat.out_valid   = out_valid_r;
  assign stat.div_done    = div_done;

  assign out_pixel_x       = out_px_r;
  assign out_pixel_y       = out_py_r;
  assign out_inside_res    = out_inside_r;
  assign out_pixel_address = out_addr_r;
  assign out_last          = out_last_r;

endmodule

// ----- rtl/core/lr_ctrl.sv -----
// Controller of the clipped line rasterizer: input handshake and the
// sequence of load steps. Depends on lr_pkg.
module lr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_cmd,
  output logic              in_tready,
  input  logic              out_tready,
  input  lr_pkg::dp_stat_t  stat,
  output lr_pkg::dp_cmd_t   cmd
);
  import lr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SUM   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIX   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE) && (!stat.out_valid || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load      = accept && (in_cmd == CMD_LOAD);
    cmd.step      = accept && (in_cmd == CMD_STEP) && stat.line_active;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.degen) begin
          cmd.degen = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/line_rasterizer_clipped.sv -----
// Clipped line rasterizer: steps a straight segment pixel by pixel and clips
// each pixel against a raster. Depends on lr_pkg, lr_ctrl, lr_dp and lr_div.
//
// Usage. Each input word carries a command in in_tuser. A load word (command
// 0) brings two endpoints in signed Q12.4 and produces no output. Each step
// word (command 1) produces the next pixel of the loaded line, with its
// column, row, an inside flag, the raster address and tlast on the final
// pixel. A step word with no line loaded is taken and produces nothing.
// The raster size is written through the cfg port (index 0 width, index 1
// height, values above 4096 saturate) while the block is idle.
//
// Timing. A step word gives its pixel in the cycle after acceptance, and
// step words are taken back to back, one pixel per cycle unless the output
// stalls. A load holds off the next word until the restoring divider has
// found the first minor coordinate (it skips the division when the
// endpoints share their major coordinate). After it, the minor coordinate
// is tracked with a remainder add and compare per pixel.
//
// Reset (rst_n low at a clock edge) drops any loaded line, empties the output
// register and sets both raster sides to 4096. When the receiver stalls the
// pixel waits in the output register and in_tready stays low until it is taken.
module line_rasterizer_clipped (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [lr_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [lr_pkg::SIDE_BITS-1:0]    cfg_wdata,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
  input  logic        in_tuser,   // cmd[0]
  // Output words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // pixel_x[12:0], pixel_y[25:13], pixel_address[49:26], zeros
  output logic        out_tuser,  // inside_res[0]
  output logic        out_tlast
);
  import lr_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  pix_t                 pixel_x, pixel_y;
  logic [ADDR_BITS-1:0] pixel_address;

  // The controller owns the input handshake and the load sequence.
  lr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the line, the raster size and the output register.
  lr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .start_x           (in_tdata[15:0]),
    .start_y           (in_tdata[31:16]),
    .end_x             (in_tdata[47:32]),
    .end_y             (in_tdata[63:48]),
    .out_tready        (out_tready),
    .out_pixel_x       (pixel_x),
    .out_pixel_y       (pixel_y),
    .out_inside_res    (out_tuser),
    .out_pixel_address (pixel_address),
    .out_last          (out_tlast)
  );

  assign out_tvalid = stat.out_valid;
  assign out_tdata  = {6'b0, pixel_address, pixel_y, pixel_x};

endmodule

// ----- dv/tb_line_rasterizer_clipped.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for line_rasterizer_clipped: directed and random lines under
// several raster sizes and idle patterns, every pixel checked against a local line model.
// Depends on lr_pkg and the line_rasterizer_clipped RTL.
module tb_line_rasterizer_clipped;
  import lr_pkg::*;

  // A load keeps the block busy and produces no pixel, so an empty queue of expected
  // pixels does not mean the block is idle; wait this long on top.
  localparam int LOAD_SETTLE = 24;
  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_WORDS = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam longint Q_ONE = longint'(1) << FRAC_BITS;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = REG_WIDTH;
  logic [SIDE_BITS-1:0]    cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
  logic        in_tuser = CMD_STEP;  // cmd[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // pixel_x[12:0], pixel_y[25:13], pixel_address[49:26], zeros
  logic        out_tuser;       // inside_res[0]
  logic        out_tlast;

  typedef struct {
    pix_t        col;
    pix_t        row;
    logic        in_raster;
    logic [23:0] addr;
    logic        is_last;
  } pixel_t;

  // Pixels that the line model has produced and the block has not delivered yet.
  pixel_t pending_pixels[$];

  // Local copy of the line being walked. Endpoints are kept in Q12.4, the walk position
  // and its end as integer pixels along the major axis.
  longint lead_major, lead_minor, span_major, span_minor;
  longint walk_major, stop_major;
  longint raster_cols, raster_rows;
  bit     major_on_x, line_loaded;

  int gap_pct, stall_pct;      // chance in percent of a sender gap / receiver stall per cycle
  int mismatches, quiet_cycles, words_sent;

  line_rasterizer_clipped i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Division that rounds toward minus infinity, for a positive divisor.
  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  // Nearest integer of a Q12.4 value, halves rounded up.
  function automatic longint round_q(longint v);
    return floor_div(2 * v + Q_ONE, 2 * Q_ONE);
  endfunction

  function automatic longint coord_of(logic [15:0] raw);
    longint v;
    v = $signed(raw);
    return v;
  endfunction

  // Register writes above the largest raster side are clamped by the block.
  function automatic longint side_of(logic [SIDE_BITS-1:0] raw);
    return (raw > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(raw);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Line model, run on each accepted word. A load orders the endpoints along the major
  // axis; a step with a line loaded yields the pixel at the current major position with
  // the minor coordinate interpolated exactly and rounded half up.
  function void trace_line_word(logic cmd, logic [63:0] data);
    longint x1, y1, x2, y2, dx, dy, a0, b0, a1, b1, tmp, num, minor, px, py;
    pixel_t pix;
    if (cmd == CMD_LOAD) begin
      x1 = coord_of(data[15:0]);
      y1 = coord_of(data[31:16]);
      x2 = coord_of(data[47:32]);
      y2 = coord_of(data[63:48]);
      dx = x2 - x1;
      dy = y2 - y1;
      // A tie between the two extents picks y as the major axis.
      major_on_x = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
      if (major_on_x) begin
        a0 = x1; b0 = y1; a1 = x2; b1 = y2;
      end else begin
        a0 = y1; b0 = x1; a1 = y2; b1 = x2;
      end
      if (a0 > a1) begin
        tmp = a0; a0 = a1; a1 = tmp;
        tmp = b0; b0 = b1; b1 = tmp;
      end
      lead_major = a0;
      lead_minor = b0;
      span_major = a1 - a0;
      span_minor = b1 - b0;
      walk_major = round_q(a0);
      stop_major = round_q(a1);
      line_loaded = 1'b1;
    end else if (line_loaded) begin
      // Equal major coordinates would divide by zero; such a line is its start point.
      if (span_major == 0) begin
        minor = round_q(lead_minor);
      end else begin
        num = lead_minor * span_major + (walk_major * Q_ONE - lead_major) * span_minor;
        minor = floor_div(2 * num + span_major * Q_ONE, 2 * span_major * Q_ONE);
      end
      px = major_on_x ? walk_major : minor;
      py = major_on_x ? minor : walk_major;
      pix.col = pix_t'(px);
      pix.row = pix_t'(py);
      pix.in_raster = (px >= 0) && (py >= 0) && (px < raster_cols) && (py < raster_rows);
      // Pixels outside the raster carry a zero address.
      pix.addr = pix.in_raster ? 24'(px + raster_cols * py) : 24'd0;
      pix.is_last = (walk_major >= stop_major);
      pending_pixels.push_back(pix);
      if (pix.is_last) line_loaded = 1'b0;
      else walk_major++;
    end
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid stays high on
  // return, so a following word goes out back to back unless a gap is drawn.
  task automatic send_word(input logic cmd, input logic [63:0] data);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    trace_line_word(cmd, data);
    words_sent++;
  endtask

  task automatic load_line(input int x0, input int y0, input int x1, input int y1);
    send_word(CMD_LOAD, {16'(y1), 16'(x1), 16'(y0), 16'(x0)});
  endtask

  // Step words carry random data, which the block must ignore.
  task automatic step_words(input int count);
    repeat (count) send_word(CMD_STEP, {$urandom, $urandom});
  endtask

  // Stops sending, waits for every expected pixel, then lets a possible load finish.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  // Writes width and then height on consecutive edges. Only called when idle.
  task automatic set_raster(input logic [SIDE_BITS-1:0] cols, input logic [SIDE_BITS-1:0] rows);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= cols;
    @(posedge clk);
    raster_cols = side_of(cols);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= rows;
    @(posedge clk);
    raster_rows = side_of(rows);
    cfg_we <= 1'b0;
  endtask

  // One random line followed by its steps. Most lines are short and walked to the end;
  // some get extra steps after the last pixel and some are cut short by the next load.
  // Half of them sit around the raster so that pixels fall inside it.
  task automatic random_line();
    int pick, span, cx, cy, pixel_count, steps;
    pick = $urandom_range(99);
    if (pick < 70) span = $urandom_range(0, 12);
    else if (pick < 90) span = $urandom_range(13, 100);
    else span = 4096;
    if ($urandom_range(1) == 1) begin
      cx = int'($urandom_range(0, int'(raster_cols) + 2)) * 16 - 16 + int'($urandom_range(15));
      cy = int'($urandom_range(0, int'(raster_rows) + 2)) * 16 - 16 + int'($urandom_range(15));
    end else begin
      cx = int'($urandom_range(65535)) - 32768;
      cy = int'($urandom_range(65535)) - 32768;
    end
    load_line(clamp_coord(cx + int'($urandom_range(0, span * 32)) - span * 16),
              clamp_coord(cy + int'($urandom_range(0, span * 32)) - span * 16),
              clamp_coord(cx + int'($urandom_range(0, span * 32)) - span * 16),
              clamp_coord(cy + int'($urandom_range(0, span * 32)) - span * 16));
    pixel_count = int'(stop_major - walk_major) + 1;
    pick = $urandom_range(99);
    if (pick < 75) steps = pixel_count;
    else if (pick < 88) steps = pixel_count + $urandom_range(1, 2);
    else steps = $urandom_range(0, pixel_count - 1);
    // Very long lines are only partly walked to keep the run short.
    if (steps > 200) steps = $urandom_range(1, 200);
    step_words(steps);
  endtask

  // Steps before any load produce nothing; a line with equal endpoints gives one pixel.
  task automatic test_step_without_line();
    step_words(2);
    load_line(0, 0, 0, 0);
    step_words(2);
  endtask

  task automatic test_directed_lines();
    // Equal extents in x and y: y is the major axis.
    load_line(16, 16, 48, 48);
    step_words(3);
    // Full range diagonal, abandoned after two pixels by the next load.
    load_line(-32768, 32767, 32767, -32768);
    step_words(2);
    // Top corner of the coordinate range, pixels reach column and row 2048.
    load_line(32736, 32767, 32767, 32767);
    step_words(3);
    // Bottom corner, endpoints given in descending order.
    load_line(-32740, -32768, -32768, -32768);
    step_words(3);
    // Minus one half rounds up to zero.
    load_line(-8, -8, -8, -8);
    step_words(1);
  endtask

  // Extreme raster settings: a single pixel, a zero height that clips everything and an
  // oversized width that saturates.
  task automatic test_raster_settings();
    drain_block();
    set_raster(13'd1, 13'd1);
    repeat (6) random_line();
    load_line(0, 0, 0, 0);
    step_words(1);
    drain_block();
    set_raster(13'd4096, 13'd0);
    repeat (6) random_line();
    drain_block();
    set_raster(13'h1fff, 13'd4097);
    repeat (6) random_line();
  endtask

  // Random lines in phases, each with its own raster size and idle pattern.
  task automatic test_random_traffic();
    int phase_end;
    for (int phase = 0; phase < 8; phase++) begin
      drain_block();
      if (phase % 4 == 0) set_raster(13'd640, 13'd480);
      else set_raster(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 62; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      phase_end = words_sent + RANDOM_WORDS / 8;
      while (words_sent < phase_end) random_line();
    end
  endtask

  // Takes each delivered pixel and compares it with the oldest expected one. The
  // receiver's ready is redrawn every cycle from the current stall chance.
  always @(posedge clk) begin : pixel_checker
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected pixel: x %0d y %0d inside %0b addr %0d last %0b",
                   $signed(out_tdata[12:0]), $signed(out_tdata[25:13]), out_tuser,
                   out_tdata[49:26], out_tlast);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[12:0] !== want.col || out_tdata[25:13] !== want.row ||
            out_tuser !== want.in_raster || out_tdata[49:26] !== want.addr ||
            out_tlast !== want.is_last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("pixel mismatch: expected x %0d y %0d inside %0b addr %0d last %0b",
                     want.col, want.row, want.in_raster, want.addr, want.is_last);
            $display("                got x %0d y %0d inside %0b addr %0d last %0b",
                     $signed(out_tdata[12:0]), $signed(out_tdata[25:13]), out_tuser,
                     out_tdata[49:26], out_tlast);
          end
        end
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_line_rasterizer_clipped failed");
      $finish;
    end
  end

  initial begin
    raster_cols = MAX_SIDE;
    raster_rows = MAX_SIDE;
    line_loaded = 1'b0;
    major_on_x = 1'b0;
    walk_major = 0;
    stop_major = 0;
    gap_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    quiet_cycles = 0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_step_without_line();
    test_directed_lines();
    test_raster_settings();
    test_random_traffic();
    drain_block();
    if (mismatches == 0) begin
      $display("tb_line_rasterizer_clipped passed");
    end else begin
      $display("tb_line_rasterizer_clipped failed");
    end
    $finish;
  end

endmodule
